### src/assert_macros.svh
// Assertion helpers for the ray/sphere block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge; idle while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/rsi_pkg.sv
// ---------------------------------------------------------------------------
// rsi_pkg
// Widths, register indexes and defaults of the ray/sphere intersect block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIR_W         = 18;
  localparam int RAD_W         = 31;
  localparam int EPS_W         = 16;
  localparam int TIME_W        = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_SPHERE_RADIUS = 3'd3,
    REG_MIN_DISTANCE  = 3'd4
  } cfg_reg_e;

  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [EPS_W-1:0] EPS_RST    = 16'd66;

endpackage

`default_nettype wire

### src/rsi_if.sv
// ---------------------------------------------------------------------------
// rsi_if
// Valid/ready channels of the ray/sphere block: rays in, hits out, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if import rsi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;
  logic signed [DIR_W-1:0]   dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_hit_if import rsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [TIME_W-1:0] hit_time;
  logic              from_inside;

  modport source (output valid, hit, hit_time, from_inside, input ready);
  modport sink   (input valid, hit, hit_time, from_inside, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/ray_sphere_intersect_top.sv
// ---------------------------------------------------------------------------
// ray_sphere_intersect_top
// Ray/sphere intersection: one ray item in, one hit item out.
//
// Channels: ray_i takes a ray (origin, direction); hit_o gives hit, hit_time
// and from_inside; cfg_i writes center, radius and min_distance by index.
// cfg_i is always ready; write it only while no ray is in flight.
// Path: a ray passes stages 1 to 6, the square root entry, the root stages
// and the final stage on its way to hit_o. SQ_W is the root width (38 at 16
// fraction bits); the square root takes one result bit per pipeline stage.
// Throughput: one ray per cycle while hit_o is ready. Every stage holds
// its own valid bit and advances when the stage after it is empty or
// advancing, so bubbles are squeezed out and rays keep entering while a
// result waits at hit_o. A stall at hit_o backs up stage by stage; nothing
// is dropped or repeated. Reset empties the pipeline and loads the default
// sphere: center at the origin, radius 1.0, min_distance 66.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ray_sphere_intersect_top import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  rsi_ray_if.sink    ray_i,
  rsi_hit_if.source  hit_o,
  rsi_cfg_if.sink    cfg_i
);

  localparam int OC_W   = COORD_W + 1;
  localparam int P_W    = OC_W + DIR_W;
  localparam int DOT_W  = P_W + 2;
  localparam int SQ1_W  = 2 * OC_W;
  localparam int OC2_W  = SQ1_W + 2;
  localparam int R2_W   = 2 * RAD_W;
  localparam int R_W    = DOT_W - FRAC_BITS;
  localparam int HW     = (R_W + 1) / 2;
  localparam int HI_W   = R_W - HW;
  localparam int MAXW   = ((OC2_W + 1) > (2 * R_W + 1)) ? (OC2_W + 1) : (2 * R_W + 1);
  localparam int H2_W   = MAXW + 1;
  localparam int SQ_W   = H2_W / 2;
  localparam int REM_W  = SQ_W + 2;
  localparam int T_W    = ((R_W > SQ_W) ? R_W : SQ_W) + 2;

  // config registers
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [RAD_W-1:0]          rad_q;
  logic [EPS_W-1:0]          eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= RADIUS_RST;
      eps_q <= EPS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CENTER_X:      cx_q  <= cfg_i.data;
        REG_CENTER_Y:      cy_q  <= cfg_i.data;
        REG_CENTER_Z:      cz_q  <= cfg_i.data;
        REG_SPHERE_RADIUS: rad_q <= cfg_i.data[RAD_W-1:0];
        REG_MIN_DISTANCE:  eps_q <= cfg_i.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vf_q;
  logic en1, en2, en3, en4, en5, en6, enf;
  logic [SQ_W:0] vs_q;
  logic [SQ_W:0] ens;

  assign enf = !vf_q || hit_o.ready;
  assign ens[SQ_W] = !vs_q[SQ_W] || enf;
  for (genvar k = 0; k < SQ_W; k++) begin : g_en
    assign ens[k] = !vs_q[k] || ens[k+1];
  end
  assign en6 = !v6_q || ens[0];
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ray_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vs_q <= '0;
      vf_q <= 1'b0;
    end else begin
      if (en1) v1_q <= ray_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (ens[0]) vs_q[0] <= v6_q;
      for (int k = 0; k < SQ_W; k++) begin
        if (ens[k+1]) vs_q[k+1] <= vs_q[k];
      end
      if (enf) vf_q <= vs_q[SQ_W];
    end
  end

  // stage 1: OC = center - origin
  logic signed [OC_W-1:0]  ocx_q, ocy_q, ocz_q;
  logic signed [DIR_W-1:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ocx_q <= {cx_q[COORD_W-1], cx_q} - {ray_i.origin_x[COORD_W-1], ray_i.origin_x};
      ocy_q <= {cy_q[COORD_W-1], cy_q} - {ray_i.origin_y[COORD_W-1], ray_i.origin_y};
      ocz_q <= {cz_q[COORD_W-1], cz_q} - {ray_i.origin_z[COORD_W-1], ray_i.origin_z};
      dx_q  <= ray_i.dir_x;
      dy_q  <= ray_i.dir_y;
      dz_q  <= ray_i.dir_z;
    end
  end

  // stage 2: products
  logic [OC_W-1:0]        mx, my, mz;
  logic signed [P_W-1:0]  px_q, py_q, pz_q;
  logic [SQ1_W-1:0]       sx_q, sy_q, sz_q;

  assign mx = ocx_q[OC_W-1] ? OC_W'(-ocx_q) : OC_W'(ocx_q);
  assign my = ocy_q[OC_W-1] ? OC_W'(-ocy_q) : OC_W'(ocy_q);
  assign mz = ocz_q[OC_W-1] ? OC_W'(-ocz_q) : OC_W'(ocz_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      px_q <= P_W'(dx_q * ocx_q);
      py_q <= P_W'(dy_q * ocy_q);
      pz_q <= P_W'(dz_q * ocz_q);
      sx_q <= mx * mx;
      sy_q <= my * my;
      sz_q <= mz * mz;
    end
  end

  // stage 3: sums, r^2
  logic signed [DOT_W-1:0] dot_q;
  logic [OC2_W-1:0]        oc2_q;
  logic [R2_W-1:0]         r2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dot_q <= DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q);
      oc2_q <= OC2_W'(sx_q) + OC2_W'(sy_q) + OC2_W'(sz_q);
      r2_q  <= rad_q * rad_q;
    end
  end

  // stage 4: R = floor(dot / 2^F), base = r^2 - |OC|^2
  logic signed [DOT_W-1:0] dot_sh;
  logic signed [R_W-1:0]   r4_q;
  logic signed [H2_W-1:0]  base4_q;

  assign dot_sh = dot_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      r4_q    <= dot_sh[R_W-1:0];
      base4_q <= $signed(H2_W'(r2_q)) - $signed(H2_W'(oc2_q));
    end
  end

  // stage 5: |R|
  logic signed [R_W-1:0]  r5_q;
  logic signed [H2_W-1:0] base5_q;
  logic [R_W-1:0]         rm5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      r5_q    <= r4_q;
      base5_q <= base4_q;
      rm5_q   <= r4_q[R_W-1] ? R_W'(-r4_q) : R_W'(r4_q);
    end
  end

  // stage 6: R^2 partial products
  logic signed [R_W-1:0]  r6_q;
  logic signed [H2_W-1:0] base6_q;
  logic [2*HW-1:0]        ll_q;
  logic [R_W-1:0]         lh_q;
  logic [2*HI_W-1:0]      hh_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      r6_q    <= r5_q;
      base6_q <= base5_q;
      ll_q    <= rm5_q[HW-1:0] * rm5_q[HW-1:0];
      lh_q    <= rm5_q[HW-1:0] * rm5_q[R_W-1:HW];
      hh_q    <= rm5_q[R_W-1:HW] * rm5_q[R_W-1:HW];
    end
  end

  // sqrt entry: h2 = base + R^2
  logic [H2_W-1:0] rr;
  logic [H2_W-1:0] h2;

  assign rr = (H2_W'(hh_q) << (2 * HW)) + (H2_W'(lh_q) << (HW + 1)) + H2_W'(ll_q);
  assign h2 = H2_W'(base6_q) + rr;

  logic [2*SQ_W-1:0]     op_q   [SQ_W+1];
  logic [REM_W-1:0]      rem_q  [SQ_W+1];
  logic [SQ_W-1:0]       root_q [SQ_W+1];
  logic signed [R_W-1:0] rs_q   [SQ_W+1];
  logic [SQ_W:0]         neg_q;

  always_ff @(posedge clk_i) begin
    if (ens[0]) begin
      op_q[0]   <= h2[2*SQ_W-1:0];
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rs_q[0]   <= r6_q;
      neg_q[0]  <= h2[H2_W-1];
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_n;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_n = {rem_q[k][SQ_W-1:0], op_q[k][2*SQ_W-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign take  = rem_n >= trial;

    always_ff @(posedge clk_i) begin
      if (ens[k+1]) begin
        op_q[k+1]   <= op_q[k] << 2;
        rem_q[k+1]  <= take ? rem_n - trial : rem_n;
        root_q[k+1] <= {root_q[k][SQ_W-2:0], take};
        rs_q[k+1]   <= rs_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end
  end

  // final stage: pick root
  logic signed [T_W-1:0] t_near, t_far, t_eps, t_sel;
  logic                  near_ok, far_ok, hit_d;
  logic [TIME_W-1:0]     time_d;
  logic                  hit_q, inside_q;
  logic [TIME_W-1:0]     time_q;

  assign t_near  = T_W'(rs_q[SQ_W]) - $signed(T_W'(root_q[SQ_W]));
  assign t_far   = T_W'(rs_q[SQ_W]) + $signed(T_W'(root_q[SQ_W]));
  assign t_eps   = $signed(T_W'(eps_q));
  assign near_ok = !neg_q[SQ_W] && (t_near > t_eps);
  assign far_ok  = !neg_q[SQ_W] && (t_far > t_eps);
  assign hit_d   = near_ok || far_ok;
  assign t_sel   = near_ok ? t_near : t_far;
  assign time_d  = !hit_d ? '0 :
                   (t_sel > $signed(T_W'({TIME_W{1'b1}}))) ? {TIME_W{1'b1}} :
                   t_sel[TIME_W-1:0];

  always_ff @(posedge clk_i) begin
    if (enf) begin
      hit_q    <= hit_d;
      inside_q <= !near_ok && far_ok;
      time_q   <= time_d;
    end
  end

  assign hit_o.valid       = vf_q;
  assign hit_o.hit         = hit_q;
  assign hit_o.hit_time    = time_q;
  assign hit_o.from_inside = inside_q;

  `ASSERT_CLK(a_miss_zero, clk_i, rst_ni, hit_o.valid && !hit_o.hit |-> hit_o.hit_time == '0 && !hit_o.from_inside, "miss item carries nonzero fields")
  `ASSERT_CLK(a_inside_hit, clk_i, rst_ni, hit_o.valid && hit_o.from_inside |-> hit_o.hit, "from_inside without hit")
  `ASSERT_CLK(a_beyond_eps, clk_i, rst_ni, hit_o.valid && hit_o.hit |-> hit_o.hit_time > TIME_W'(eps_q), "hit time not beyond min_distance")
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !hit_o.valid, "output valid during reset")

endmodule

`default_nettype wire
